>>> rtl/tlbt_pkg.sv
// ----------------------------------------------------------------------------
// tlbt_pkg
// Shared constants, result codes and the entry update type of the TLB
// translator.
// ----------------------------------------------------------------------------
package tlbt_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_BITS_DEF   = 10;
  localparam int FRAME_BITS_DEF  = 16;

  localparam int STATUS_W = 2;
  localparam int LAT_W    = 7;
  localparam int STAT_W   = 32;

  localparam logic [STATUS_W-1:0] STAT_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_HIT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FILL   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FAULT  = 2'd3;

  localparam logic [LAT_W-1:0] TLB_HIT_NS    = 7'd20;
  localparam logic [LAT_W-1:0] MEM_ACCESS_NS = 7'd100;

  typedef struct packed {
    logic touch;
    logic fill;
  } tlbt_upd_t;

endpackage

>>> rtl/tlbt_page_table.sv
// ----------------------------------------------------------------------------
// tlbt_page_table
// Page table store: one write port and one read port with registered read
// data. Each word holds the present flag above the frame number.
// ----------------------------------------------------------------------------
module tlbt_page_table #(
  parameter int PAGE_BITS  = tlbt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbt_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [PAGE_BITS-1:0]  wr_addr,
  input  logic [FRAME_BITS:0]   wr_data,
  input  logic                  rd_en,
  input  logic [PAGE_BITS-1:0]  rd_addr,
  output logic [FRAME_BITS:0]   rd_data
);
  import tlbt_pkg::*;

  localparam int DEPTH = 1 << PAGE_BITS;

  logic [FRAME_BITS:0] mem [DEPTH];
  logic [FRAME_BITS:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tlbt_entry_array.sv
// ----------------------------------------------------------------------------
// tlbt_entry_array
// Fully associative entry array: tag compare, free slot and LRU victim
// selection, recency ranks, and the frame store with registered read.
// ----------------------------------------------------------------------------
module tlbt_entry_array #(
  parameter int TLB_ENTRIES = tlbt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_BITS   = tlbt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS  = tlbt_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(TLB_ENTRIES+1)-1:0] used_n,
  input  logic                             lookup_en,
  input  logic [PAGE_BITS-1:0]             lookup_page,
  output logic                             hit,
  output logic [$clog2(TLB_ENTRIES)-1:0]   hit_idx,
  output logic [$clog2(TLB_ENTRIES)-1:0]   slot_idx,
  output logic [FRAME_BITS-1:0]            hit_frame,
  input  tlbt_pkg::tlbt_upd_t              upd,
  input  logic [$clog2(TLB_ENTRIES)-1:0]   upd_idx,
  input  logic [PAGE_BITS-1:0]             upd_page,
  input  logic [FRAME_BITS-1:0]            upd_frame
);
  import tlbt_pkg::*;

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam int CFG_W = $clog2(TLB_ENTRIES+1);
  localparam int LVL   = IDX_W;
  localparam int PAD   = 1 << LVL;
  localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(TLB_ENTRIES - 1);

  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] valid_nxt;
  logic [PAGE_BITS-1:0]   tag_r    [TLB_ENTRIES];
  logic [IDX_W-1:0]       rank_r   [TLB_ENTRIES];
  logic [IDX_W-1:0]       rank_nxt [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  frame_mem [TLB_ENTRIES];

  logic [TLB_ENTRIES-1:0] active;
  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_ENTRIES-1:0] free;
  logic [IDX_W-1:0]       hit_idx_c;
  logic [IDX_W-1:0]       free_idx_c;
  logic [IDX_W-1:0]       victim_c;

  logic                   t_ok   [LVL+1][PAD];
  logic [IDX_W-1:0]       t_rank [LVL+1][PAD];
  logic [IDX_W-1:0]       t_idx  [LVL+1][PAD];

  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [IDX_W-1:0]       slot_idx_r;
  logic [FRAME_BITS-1:0]  hit_frame_r;
  logic [IDX_W-1:0]       old_rank;

  // compare and priority encode
  always_comb begin
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      active[i] = (CFG_W'(i) < used_n);
      match[i]  = active[i] && valid_r[i] && (tag_r[i] == lookup_page);
      free[i]   = active[i] && !valid_r[i];
    end
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_c = IDX_W'(i);
      end
      if (free[i]) begin
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // lowest rank over active entries, lower index wins a tie
  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int j = 0; j < PAD; j++) begin
        t_ok[l][j]   = 1'b0;
        t_rank[l][j] = '0;
        t_idx[l][j]  = '0;
      end
    end
    for (int j = 0; j < TLB_ENTRIES; j++) begin
      t_ok[0][j]   = active[j];
      t_rank[0][j] = rank_r[j];
      t_idx[0][j]  = IDX_W'(j);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j < PAD / 2; j++) begin
        if (t_ok[l][2*j] &&
            (!t_ok[l][2*j+1] || (t_rank[l][2*j] <= t_rank[l][2*j+1]))) begin
          t_ok[l+1][j]   = t_ok[l][2*j];
          t_rank[l+1][j] = t_rank[l][2*j];
          t_idx[l+1][j]  = t_idx[l][2*j];
        end else begin
          t_ok[l+1][j]   = t_ok[l][2*j+1];
          t_rank[l+1][j] = t_rank[l][2*j+1];
          t_idx[l+1][j]  = t_idx[l][2*j+1];
        end
      end
    end
    victim_c = t_idx[LVL][0];
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      hit_r       <= |match;
      hit_idx_r   <= hit_idx_c;
      slot_idx_r  <= (|free) ? free_idx_c : victim_c;
      hit_frame_r <= frame_mem[hit_idx_c];
    end
  end

  // recency update and fill
  always_comb begin
    old_rank  = rank_r[upd_idx];
    valid_nxt = valid_r;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (upd.touch) begin
        if (IDX_W'(i) == upd_idx) begin
          rank_nxt[i] = TOP_RANK;
        end else if (rank_r[i] > old_rank) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
    end
    if (upd.fill) begin
      valid_nxt[upd_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.fill) begin
      tag_r[upd_idx]     <= upd_page;
      frame_mem[upd_idx] <= upd_frame;
    end
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign slot_idx  = slot_idx_r;
  assign hit_frame = hit_frame_r;

endmodule

>>> rtl/tlb_lru_translator_core.sv
// ----------------------------------------------------------------------------
// tlb_lru_translator_core
// Fully associative TLB with LRU replacement backed by a page table store.
//
// Request channel in_*: valid/stall. in_mode 0 loads or removes a page table
// mapping, in_mode 1 translates in_page. Every request returns one result on
// out_* (valid/stall) with status, frame, entry index, modeled latency and
// the running access, hit and miss counts.
// At accept the page table read and the tag compare are registered; the
// commit step then writes the entry update and loads the output register.
// Requests are taken one at a time: in_stall stays high from accept until
// the commit, which waits for the page table read ahead of the update.
// A new request is accepted while the previous result waits in the output
// register; if the receiver stalls, the second result holds in the commit
// step and in_stall stays high until the output register frees.
// cfg_*: valid/ready write of the number of active entries, always ready.
// After reset the page table is cleared one word per cycle, all 2**PAGE_BITS
// words (1024 at default), with in_stall high; config writes are taken.
// ----------------------------------------------------------------------------
module tlb_lru_translator_core #(
  parameter int TLB_ENTRIES = tlbt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_BITS   = tlbt_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS  = tlbt_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [PAGE_BITS-1:0]             in_page,
  input  logic [FRAME_BITS-1:0]            in_frame,
  input  logic                             in_present,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tlbt_pkg::STATUS_W-1:0]    out_status,
  output logic [FRAME_BITS-1:0]            out_frame_out,
  output logic [$clog2(TLB_ENTRIES)-1:0]   out_entry_index,
  output logic [tlbt_pkg::LAT_W-1:0]       out_latency_ns,
  output logic [tlbt_pkg::STAT_W-1:0]      out_access_count,
  output logic [tlbt_pkg::STAT_W-1:0]      out_hit_count,
  output logic [tlbt_pkg::STAT_W-1:0]      out_miss_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [$clog2(TLB_ENTRIES+1)-1:0] cfg_data
);
  import tlbt_pkg::*;

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam int CFG_W = $clog2(TLB_ENTRIES+1);
  localparam logic [CFG_W-1:0] MAX_USED = CFG_W'(TLB_ENTRIES);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [PAGE_BITS-1:0]  clr_cnt_r;
  logic [CFG_W-1:0]      cfg_r;
  logic [CFG_W-1:0]      used_n;

  logic                  accept;
  logic                  commit;
  logic                  req_mode_r;
  logic [PAGE_BITS-1:0]  req_page_r;

  logic                  pt_we;
  logic [PAGE_BITS-1:0]  pt_waddr;
  logic [FRAME_BITS:0]   pt_wdata;
  logic [FRAME_BITS:0]   pt_rdata;
  logic                  pt_present;
  logic [FRAME_BITS-1:0] pt_frame;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      slot_idx;
  logic [FRAME_BITS-1:0] hit_frame;
  tlbt_upd_t             upd;
  logic [IDX_W-1:0]      upd_idx;

  logic [STATUS_W-1:0]   status_c;
  logic [FRAME_BITS-1:0] frame_c;
  logic [IDX_W-1:0]      index_c;
  logic [LAT_W-1:0]      lat_c;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [FRAME_BITS-1:0] out_frame_r;
  logic [IDX_W-1:0]      out_index_r;
  logic [LAT_W-1:0]      out_lat_r;
  logic [STAT_W-1:0]     acc_r, hits_r, miss_r;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign commit    = (state_r == S_LOOK) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_r == '0) begin
      used_n = CFG_W'(1);
    end else if (cfg_r > MAX_USED) begin
      used_n = MAX_USED;
    end else begin
      used_n = cfg_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      cfg_r     <= MAX_USED;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= in_mode;
      req_page_r <= in_page;
    end
  end

  // page table port: clear sweep or load request
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = in_page;
    pt_wdata = {in_present, in_present ? in_frame : {FRAME_BITS{1'b0}}};
    if (state_r == S_CLEAR) begin
      pt_we    = 1'b1;
      pt_waddr = clr_cnt_r;
      pt_wdata = '0;
    end else if (accept && !in_mode) begin
      pt_we = 1'b1;
    end
  end

  tlbt_page_table #(
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_page_table (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_waddr),
    .wr_data (pt_wdata),
    .rd_en   (accept && in_mode),
    .rd_addr (in_page),
    .rd_data (pt_rdata)
  );

  assign pt_present = pt_rdata[FRAME_BITS];
  assign pt_frame   = pt_rdata[FRAME_BITS-1:0];

  assign upd.touch = commit && req_mode_r && (hit || pt_present);
  assign upd.fill  = commit && req_mode_r && !hit && pt_present;
  assign upd_idx   = hit ? hit_idx : slot_idx;

  tlbt_entry_array #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_entry_array (
    .clk         (clk),
    .rst_n       (rst_n),
    .used_n      (used_n),
    .lookup_en   (accept && in_mode),
    .lookup_page (in_page),
    .hit         (hit),
    .hit_idx     (hit_idx),
    .slot_idx    (slot_idx),
    .hit_frame   (hit_frame),
    .upd         (upd),
    .upd_idx     (upd_idx),
    .upd_page    (req_page_r),
    .upd_frame   (pt_frame)
  );

  always_comb begin
    status_c = STAT_LOADED;
    frame_c  = '0;
    index_c  = '0;
    lat_c    = '0;
    if (req_mode_r) begin
      if (hit) begin
        status_c = STAT_HIT;
        frame_c  = hit_frame;
        index_c  = hit_idx;
        lat_c    = TLB_HIT_NS;
      end else if (pt_present) begin
        status_c = STAT_FILL;
        frame_c  = pt_frame;
        index_c  = slot_idx;
        lat_c    = TLB_HIT_NS + MEM_ACCESS_NS;
      end else begin
        status_c = STAT_FAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
    end else begin
      out_valid_r <= commit || (out_valid_r && out_stall);
      if (commit && req_mode_r) begin
        acc_r <= acc_r + 1'b1;
        if (hit) begin
          hits_r <= hits_r + 1'b1;
        end else begin
          miss_r <= miss_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status_c;
      out_frame_r  <= frame_c;
      out_index_r  <= index_c;
      out_lat_r    <= lat_c;
    end
  end

  // counters move only at commit, which waits for the output register
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_out    = out_frame_r;
  assign out_entry_index  = out_index_r;
  assign out_latency_ns   = out_lat_r;
  assign out_access_count = acc_r;
  assign out_hit_count    = hits_r;
  assign out_miss_count   = miss_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tlb_lru_translator_core. Load and translate
// requests go through a directed table and then random phases built around
// a small set of working pages, each phase under a different active-entry
// setting. Every accepted request is run through a behavioral copy of the
// TLB, its page table and its LRU ranks. Each result is compared field by
// field with the oldest pending expected result. Both handshakes idle at random,
// and one phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import tlbt_pkg::*;

  localparam int NENT    = TLB_ENTRIES_DEF;
  localparam int PAGE_W  = PAGE_BITS_DEF;
  localparam int FRAME_W = FRAME_BITS_DEF;
  localparam int IDX_W   = $clog2(NENT);
  localparam int CFG_W   = $clog2(NENT + 1);
  localparam int PT_SIZE = 1 << PAGE_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_XLAT = 1'b1;

  localparam int RESET_CYCLES    = 12;
  localparam int MAX_GAP         = 12;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_PAD       = 8;
  localparam int DIR_ROWS        = 23;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int WORK_SET        = 24;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic               mode;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               present;
  } xlat_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic [IDX_W-1:0]    entry;
    logic [LAT_W-1:0]    lat;
    logic [STAT_W-1:0]   acc;
    logic [STAT_W-1:0]   hit;
    logic [STAT_W-1:0]   miss;
  } xlat_rsp_t;

  typedef struct packed {
    logic             cfg_en;
    logic [CFG_W-1:0] cfg_val;
    xlat_req_t        req;
    logic             typed;
    xlat_rsp_t        rsp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [PAGE_W-1:0]  in_page;
  logic [FRAME_W-1:0] in_frame;
  logic               in_present;
  logic               out_valid;
  logic               out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0] out_frame_out;
  logic [IDX_W-1:0]   out_entry_index;
  logic [LAT_W-1:0]   out_latency_ns;
  logic [STAT_W-1:0]  out_access_count;
  logic [STAT_W-1:0]  out_hit_count;
  logic [STAT_W-1:0]  out_miss_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  tlb_lru_translator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_page          (in_page),
    .in_frame         (in_frame),
    .in_present       (in_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_out    (out_frame_out),
    .out_entry_index  (out_entry_index),
    .out_latency_ns   (out_latency_ns),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // behavioral copy of the translator
  logic               pt_present [PT_SIZE];
  logic [FRAME_W-1:0] pt_frame   [PT_SIZE];
  logic               ent_valid  [NENT];
  logic [PAGE_W-1:0]  ent_page   [NENT];
  logic [FRAME_W-1:0] ent_frame  [NENT];
  logic [IDX_W-1:0]   lru_rank   [NENT];
  logic [STAT_W-1:0]  acc_cnt;
  logic [STAT_W-1:0]  hit_cnt;
  logic [STAT_W-1:0]  miss_cnt;
  logic [CFG_W-1:0]   act_entries;

  xlat_rsp_t pending_rsp_q [$];
  xlat_rsp_t got_exp;

  int  err_cnt;
  int  cycle_cnt;
  int  n_load, n_hit, n_fill, n_fault, n_cfg;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void lru_promote(int e);
    logic [IDX_W-1:0] old;
    old = lru_rank[e];
    for (int i = 0; i < NENT; i++) begin
      if (lru_rank[i] > old) lru_rank[i] = lru_rank[i] - 1'b1;
    end
    lru_rank[e] = IDX_W'(NENT - 1);
  endfunction

  function automatic xlat_rsp_t tlb_predict(xlat_req_t r);
    xlat_rsp_t o;
    int        n;
    int        e;
    int        victim;
    o = '0;
    if (r.mode == MODE_LOAD) begin
      pt_present[r.page] = r.present;
      pt_frame[r.page]   = r.present ? r.frame : '0;
    end else begin
      n = (act_entries < 1) ? 1 : ((act_entries > NENT) ? NENT : int'(act_entries));
      acc_cnt = acc_cnt + 1'b1;
      e = -1;
      for (int i = 0; i < n; i++) begin
        if (e < 0 && ent_valid[i] && ent_page[i] == r.page) e = i;
      end
      if (e >= 0) begin
        hit_cnt = hit_cnt + 1'b1;
        lru_promote(e);
        o.status = STAT_HIT;
        o.frame  = ent_frame[e];
        o.entry  = IDX_W'(e);
        o.lat    = TLB_HIT_NS;
      end else begin
        miss_cnt = miss_cnt + 1'b1;
        if (pt_present[r.page]) begin
          victim = -1;
          for (int i = 0; i < n; i++) begin
            if (victim < 0 && !ent_valid[i]) victim = i;
          end
          if (victim < 0) begin
            victim = 0;
            for (int i = 1; i < n; i++) begin
              if (lru_rank[i] < lru_rank[victim]) victim = i;
            end
          end
          ent_valid[victim] = 1'b1;
          ent_page[victim]  = r.page;
          ent_frame[victim] = pt_frame[r.page];
          lru_promote(victim);
          o.status = STAT_FILL;
          o.frame  = ent_frame[victim];
          o.entry  = IDX_W'(victim);
          o.lat    = TLB_HIT_NS + MEM_ACCESS_NS;
        end else begin
          o.status = STAT_FAULT;
        end
      end
    end
    o.acc  = acc_cnt;
    o.hit  = hit_cnt;
    o.miss = miss_cnt;
    return o;
  endfunction

  function automatic dir_row_t mk_row(
    logic cfg_en, logic [CFG_W-1:0] cfg_v, logic mode, logic [PAGE_W-1:0] page,
    logic [FRAME_W-1:0] frame, logic present, logic typed,
    logic [STATUS_W-1:0] st, logic [FRAME_W-1:0] fo, logic [IDX_W-1:0] idx,
    logic [LAT_W-1:0] lat, logic [STAT_W-1:0] acc, logic [STAT_W-1:0] hit,
    logic [STAT_W-1:0] miss);
    dir_row_t row;
    row.cfg_en      = cfg_en;
    row.cfg_val     = cfg_v;
    row.req.mode    = mode;
    row.req.page    = page;
    row.req.frame   = frame;
    row.req.present = present;
    row.typed       = typed;
    row.rsp.status  = st;
    row.rsp.frame   = fo;
    row.rsp.entry   = idx;
    row.rsp.lat     = lat;
    row.rsp.acc     = acc;
    row.rsp.hit     = hit;
    row.rsp.miss    = miss;
    return row;
  endfunction

  function automatic int tx_gap();
    return tx_idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic xlat_req_t rand_req(logic [PAGE_W-1:0] base);
    xlat_req_t r;
    r.mode = ($urandom_range(0, 99) < 30) ? MODE_LOAD : MODE_XLAT;
    if ($urandom_range(0, 9) == 0) r.page = PAGE_W'($urandom);
    else r.page = base + PAGE_W'($urandom_range(0, WORK_SET - 1));
    r.frame   = FRAME_W'($urandom);
    r.present = ($urandom_range(0, 9) < 8);
    return r;
  endfunction

  task automatic send_req(xlat_req_t r, int gap, logic typed, xlat_rsp_t typed_rsp);
    xlat_rsp_t pred;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= r.mode;
    in_page    <= r.page;
    in_frame   <= r.frame;
    in_present <= r.present;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = tlb_predict(r);
    pending_rsp_q.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_active(logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    act_entries  = v;
    n_cfg++;
  endtask

  task automatic check_field(string name, logic [STAT_W-1:0] exp_v, logic [STAT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // result side
  initial begin : rx_proc
    int hold;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = rx_idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (rx_hold_req) begin
        hold        = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: result with no pending request, status %0d", $time, out_status);
        err_cnt++;
      end else begin
        got_exp = pending_rsp_q.pop_front();
        check_field("status", STAT_W'(got_exp.status), STAT_W'(out_status));
        check_field("frame_out", STAT_W'(got_exp.frame), STAT_W'(out_frame_out));
        check_field("entry_index", STAT_W'(got_exp.entry), STAT_W'(out_entry_index));
        check_field("latency_ns", STAT_W'(got_exp.lat), STAT_W'(out_latency_ns));
        check_field("access_count", got_exp.acc, out_access_count);
        check_field("hit_count", got_exp.hit, out_hit_count);
        check_field("miss_count", got_exp.miss, out_miss_count);
        case (got_exp.status)
          STAT_LOADED: n_load++;
          STAT_HIT:    n_hit++;
          STAT_FILL:   n_fill++;
          default:     n_fault++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t         tab [DIR_ROWS];
    logic [CFG_W-1:0] phase_cfg [PHASES];
    logic [PAGE_W-1:0] base;
    xlat_req_t        r;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_LOAD;
    in_page    <= '0;
    in_frame   <= '0;
    in_present <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    cycle_cnt   = 0;
    err_cnt     = 0;
    n_load = 0; n_hit = 0; n_fill = 0; n_fault = 0; n_cfg = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b0;
    for (int i = 0; i < PT_SIZE; i++) begin
      pt_present[i] = 1'b0;
      pt_frame[i]   = '0;
    end
    for (int i = 0; i < NENT; i++) begin
      ent_valid[i] = 1'b0;
      ent_page[i]  = '0;
      ent_frame[i] = '0;
      lru_rank[i]  = '0;
    end
    acc_cnt     = '0;
    hit_cnt     = '0;
    miss_cnt    = '0;
    act_entries = CFG_W'(NENT);

    // faults on empty table, extreme pages and frames, stale and removed mappings
    tab[0]  = mk_row(0, 0, MODE_XLAT, 10'd0, 16'h0000, 0, 1,
                     STAT_FAULT, 16'h0000, 0, 0, 1, 0, 1);
    tab[1]  = mk_row(0, 0, MODE_XLAT, 10'd1023, 16'hffff, 1, 1,
                     STAT_FAULT, 16'h0000, 0, 0, 2, 0, 2);
    tab[2]  = mk_row(0, 0, MODE_LOAD, 10'd0, 16'hffff, 1, 1,
                     STAT_LOADED, 16'h0000, 0, 0, 2, 0, 2);
    tab[3]  = mk_row(0, 0, MODE_LOAD, 10'd1023, 16'h0000, 1, 1,
                     STAT_LOADED, 16'h0000, 0, 0, 2, 0, 2);
    tab[4]  = mk_row(0, 0, MODE_XLAT, 10'd0, 16'h0000, 0, 1,
                     STAT_FILL, 16'hffff, 0, 7'd120, 3, 0, 3);
    tab[5]  = mk_row(0, 0, MODE_XLAT, 10'd0, 16'h0000, 0, 1,
                     STAT_HIT, 16'hffff, 0, 7'd20, 4, 1, 3);
    tab[6]  = mk_row(0, 0, MODE_XLAT, 10'd1023, 16'h0000, 0, 1,
                     STAT_FILL, 16'h0000, 1, 7'd120, 5, 1, 4);
    tab[7]  = mk_row(0, 0, MODE_LOAD, 10'd0, 16'h1234, 1, 1,
                     STAT_LOADED, 16'h0000, 0, 0, 5, 1, 4);
    tab[8]  = mk_row(0, 0, MODE_XLAT, 10'd0, 16'h0000, 0, 1,
                     STAT_HIT, 16'hffff, 0, 7'd20, 6, 2, 4);
    tab[9]  = mk_row(0, 0, MODE_LOAD, 10'd1023, 16'habcd, 0, 1,
                     STAT_LOADED, 16'h0000, 0, 0, 6, 2, 4);
    tab[10] = mk_row(0, 0, MODE_XLAT, 10'd1023, 16'h0000, 0, 1,
                     STAT_HIT, 16'h0000, 1, 7'd20, 7, 3, 4);
    tab[11] = mk_row(0, 0, MODE_LOAD, 10'h155, 16'haaaa, 1, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[12] = mk_row(0, 0, MODE_LOAD, 10'h2aa, 16'h5555, 1, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[13] = mk_row(0, 0, MODE_XLAT, 10'h155, 16'hffff, 1, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[14] = mk_row(0, 0, MODE_XLAT, 10'h2aa, 16'h0000, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[15] = mk_row(0, 0, MODE_XLAT, 10'd5, 16'hffff, 1, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    // zero active entries acts as one, outer entries unreachable
    tab[16] = mk_row(1, 5'd0, MODE_XLAT, 10'd1023, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[17] = mk_row(0, 0, MODE_LOAD, 10'd1023, 16'h0007, 1, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[18] = mk_row(0, 0, MODE_XLAT, 10'd1023, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[19] = mk_row(0, 0, MODE_XLAT, 10'd0, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    // above the entry count acts as the full tlb
    tab[20] = mk_row(1, 5'd31, MODE_XLAT, 10'd1023, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[21] = mk_row(1, 5'd16, MODE_XLAT, 10'h155, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);
    tab[22] = mk_row(1, 5'd1, MODE_XLAT, 10'd0, 16'h0, 0, 0, STAT_LOADED, 0, 0, 0, 0, 0, 0);

    phase_cfg[0] = CFG_W'(1);
    phase_cfg[1] = CFG_W'(NENT);
    phase_cfg[2] = CFG_W'(0);
    phase_cfg[3] = CFG_W'(31);
    phase_cfg[4] = CFG_W'($urandom_range(2, NENT - 1));
    phase_cfg[5] = CFG_W'($urandom_range(NENT + 1, 30));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (tab[k].cfg_en) write_active(tab[k].cfg_val);
      send_req(tab[k].req, tx_gap(), tab[k].typed, tab[k].rsp);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_active(phase_cfg[p]);
      tx_idle_en = (p != 4);
      rx_idle_en = (p != 2 && p != 4);
      base       = PAGE_W'($urandom);
      // back-to-back requests against a long result stall
      if (p == 1) rx_hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == ITEMS_PER_PHASE / 2) drain_results();
        r = rand_req(base);
        send_req(r, (p == 1 && i < 40) ? 0 : tx_gap(), 1'b0, '0);
      end
    end

    drain_results();
    $display("Run covered %0d loads, %0d hits, %0d fills and %0d faults", n_load, n_hit,
             n_fill, n_fault);
    $display("across %0d active-entry settings, extremes included", n_cfg);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
